[hw/rtl/z80sid_pkg.sv]
// ----------------------------------------------------------------------------
// z80sid_pkg
// Shared kind codes, opcode constants and the decoded-instruction record
// for the Z80 subset instruction decoder.
// ----------------------------------------------------------------------------
package z80sid_pkg;

	localparam int unsigned KIND_W = 6;
	localparam int unsigned LEN_W  = 3;
	localparam int unsigned IMM_W  = 16;
	localparam int unsigned REG_W  = 3;

	// kind codes, dense in check order
	localparam logic [KIND_W-1:0] K_UNKNOWN = 6'd0;
	localparam logic [KIND_W-1:0] K_NOP     = 6'd1;
	localparam logic [KIND_W-1:0] K_HALT    = 6'd2;
	localparam logic [KIND_W-1:0] K_RET     = 6'd3;
	localparam logic [KIND_W-1:0] K_JP      = 6'd4;
	localparam logic [KIND_W-1:0] K_JR      = 6'd5;
	localparam logic [KIND_W-1:0] K_CALL    = 6'd6;
	localparam logic [KIND_W-1:0] K_LD_NN_A = 6'd7;
	localparam logic [KIND_W-1:0] K_LD_A_NN = 6'd8;
	localparam logic [KIND_W-1:0] K_IX_BASE = 6'd9;
	localparam logic [KIND_W-1:0] K_IY_BASE = 6'd18;
	localparam logic [KIND_W-1:0] K_LD_HL_R = 6'd27;
	localparam logic [KIND_W-1:0] K_LD_R_HL = 6'd28;
	localparam logic [KIND_W-1:0] K_LD_R_R  = 6'd29;
	localparam logic [KIND_W-1:0] K_LD_R_N  = 6'd30;
	localparam logic [KIND_W-1:0] K_ADD_R   = 6'd31;
	localparam logic [KIND_W-1:0] K_SUB_R   = 6'd32;
	localparam logic [KIND_W-1:0] K_CP_R    = 6'd33;
	localparam logic [KIND_W-1:0] K_INC_R   = 6'd34;
	localparam logic [KIND_W-1:0] K_DEC_R   = 6'd35;
	localparam logic [KIND_W-1:0] K_AND_R   = 6'd36;
	localparam logic [KIND_W-1:0] K_OR_R    = 6'd37;
	localparam logic [KIND_W-1:0] K_XOR_R   = 6'd38;
	localparam logic [KIND_W-1:0] K_PUSH    = 6'd39;
	localparam logic [KIND_W-1:0] K_POP     = 6'd40;

	// offsets of indexed forms from the IX/IY base
	localparam logic [KIND_W-1:0] OFF_LD_I_N   = 6'd0;
	localparam logic [KIND_W-1:0] OFF_LD_I_R   = 6'd1;
	localparam logic [KIND_W-1:0] OFF_LD_R_I   = 6'd2;
	localparam logic [KIND_W-1:0] OFF_ADD_I    = 6'd3;
	localparam logic [KIND_W-1:0] OFF_SUB_I    = 6'd4;
	localparam logic [KIND_W-1:0] OFF_AND_I    = 6'd5;
	localparam logic [KIND_W-1:0] OFF_XOR_I    = 6'd6;
	localparam logic [KIND_W-1:0] OFF_OR_I     = 6'd7;
	localparam logic [KIND_W-1:0] OFF_CP_I     = 6'd8;
	localparam logic [KIND_W-1:0] OFF_NONE     = 6'd0;

	// ALU operation field (bits 5..3)
	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_SUB = 3'd2;
	localparam logic [2:0] ALU_AND = 3'd4;
	localparam logic [2:0] ALU_XOR = 3'd5;
	localparam logic [2:0] ALU_OR  = 3'd6;
	localparam logic [2:0] ALU_CP  = 3'd7;

	localparam logic [2:0] REG_MEM = 3'd6;

	// opcodes and masks
	localparam logic [7:0] OP_NOP      = 8'h00;
	localparam logic [7:0] OP_HALT     = 8'h76;
	localparam logic [7:0] OP_RET      = 8'hC9;
	localparam logic [7:0] OP_JP       = 8'hC3;
	localparam logic [7:0] OP_JR       = 8'h18;
	localparam logic [7:0] OP_CALL     = 8'hCD;
	localparam logic [7:0] OP_LD_NN_A  = 8'h32;
	localparam logic [7:0] OP_LD_A_NN  = 8'h3A;
	localparam logic [7:0] OP_PFX_IX   = 8'hDD;
	localparam logic [7:0] OP_PFX_IY   = 8'hFD;
	localparam logic [7:0] OP_LD_I_N   = 8'h36;
	localparam logic [7:0] MASK_F8     = 8'hF8;
	localparam logic [7:0] MASK_C7     = 8'hC7;
	localparam logic [7:0] MASK_C0     = 8'hC0;
	localparam logic [7:0] MASK_CF     = 8'hCF;
	localparam logic [7:0] PAT_LD_I_R  = 8'h70;
	localparam logic [7:0] PAT_LD_R_I  = 8'h46;
	localparam logic [7:0] PAT_ALU_I   = 8'h86;
	localparam logic [7:0] PAT_LD_RR   = 8'h40;
	localparam logic [7:0] PAT_LD_R_N  = 8'h06;
	localparam logic [7:0] PAT_ADD_R   = 8'h80;
	localparam logic [7:0] PAT_SUB_R   = 8'h90;
	localparam logic [7:0] PAT_CP_R    = 8'hB8;
	localparam logic [7:0] PAT_INC_R   = 8'h04;
	localparam logic [7:0] PAT_DEC_R   = 8'h05;
	localparam logic [7:0] PAT_AND_R   = 8'hA0;
	localparam logic [7:0] PAT_OR_R    = 8'hB0;
	localparam logic [7:0] PAT_XOR_R   = 8'hA8;
	localparam logic [7:0] PAT_PUSH    = 8'hC5;
	localparam logic [7:0] PAT_POP     = 8'hC1;

	localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

	typedef struct packed {
		logic [REG_W-1:0]  dest_register;
		logic [REG_W-1:0]  source_register;
		logic [IMM_W-1:0]  immediate;
		logic [LEN_W-1:0]  length;
		logic [KIND_W-1:0] kind;
	} dec_t;

	typedef struct packed {
		logic [7:0] fourth_byte;
		logic [7:0] third_byte;
		logic [7:0] second_byte;
		logic [7:0] first_byte;
	} fetch_t;

endpackage

[hw/rtl/z80sid_indexed.sv]
// ----------------------------------------------------------------------------
// z80sid_indexed
// Decodes the byte after a DD/FD prefix into the indexed LD and ALU forms.
// ----------------------------------------------------------------------------
module z80sid_indexed (
	input  logic [z80sid_pkg::KIND_W-1:0] base,
	input  logic [7:0]                    op2,
	input  logic [7:0]                    disp,
	input  logic [7:0]                    imm_n,
	output z80sid_pkg::dec_t              dec
);

	logic [z80sid_pkg::KIND_W-1:0] alu_off;

	always_comb begin
		unique case (op2[5:3])
			z80sid_pkg::ALU_ADD: alu_off = z80sid_pkg::OFF_ADD_I;
			z80sid_pkg::ALU_SUB: alu_off = z80sid_pkg::OFF_SUB_I;
			z80sid_pkg::ALU_AND: alu_off = z80sid_pkg::OFF_AND_I;
			z80sid_pkg::ALU_XOR: alu_off = z80sid_pkg::OFF_XOR_I;
			z80sid_pkg::ALU_OR:  alu_off = z80sid_pkg::OFF_OR_I;
			z80sid_pkg::ALU_CP:  alu_off = z80sid_pkg::OFF_CP_I;
			default:             alu_off = z80sid_pkg::OFF_NONE; // ADC, SBC
		endcase
	end

	always_comb begin
		dec = '0;
		if (op2 == z80sid_pkg::OP_LD_I_N) begin
			dec.kind      = base + z80sid_pkg::OFF_LD_I_N;
			dec.length    = z80sid_pkg::LEN_4;
			dec.immediate = {disp, imm_n};
		end else if ((op2 & z80sid_pkg::MASK_F8) == z80sid_pkg::PAT_LD_I_R &&
				op2[2:0] != z80sid_pkg::REG_MEM) begin
			dec.kind            = base + z80sid_pkg::OFF_LD_I_R;
			dec.length          = z80sid_pkg::LEN_3;
			dec.immediate       = {8'h00, disp};
			dec.source_register = op2[2:0];
		end else if ((op2 & z80sid_pkg::MASK_C7) == z80sid_pkg::PAT_LD_R_I) begin
			dec.kind          = base + z80sid_pkg::OFF_LD_R_I;
			dec.length        = z80sid_pkg::LEN_3;
			dec.immediate     = {8'h00, disp};
			dec.dest_register = op2[5:3];
		end else if ((op2 & z80sid_pkg::MASK_C7) == z80sid_pkg::PAT_ALU_I) begin
			// ADC/SBC stay unknown but still span the displacement
			dec.kind      = (alu_off != z80sid_pkg::OFF_NONE) ? base + alu_off
				: z80sid_pkg::K_UNKNOWN;
			dec.length    = z80sid_pkg::LEN_3;
			dec.immediate = {8'h00, disp};
		end else begin
			dec.kind   = z80sid_pkg::K_UNKNOWN;
			dec.length = z80sid_pkg::LEN_2;
		end
	end

endmodule

[hw/rtl/z80sid_decode.sv]
// ----------------------------------------------------------------------------
// z80sid_decode
// Single-pass decode of the four fetched bytes into kind, length, operand
// and register fields.
// ----------------------------------------------------------------------------
module z80sid_decode (
	input  z80sid_pkg::fetch_t fetch,
	output z80sid_pkg::dec_t   dec
);

	logic [7:0]                    b0;
	logic [2:0]                    hi;
	logic [2:0]                    lo;
	logic [z80sid_pkg::KIND_W-1:0] idx_base;
	z80sid_pkg::dec_t              idx_dec;

	assign b0 = fetch.first_byte;
	assign hi = b0[5:3];
	assign lo = b0[2:0];
	assign idx_base = (b0 == z80sid_pkg::OP_PFX_IY) ? z80sid_pkg::K_IY_BASE
		: z80sid_pkg::K_IX_BASE;

	z80sid_indexed u_indexed (
		.base  (idx_base),
		.op2   (fetch.second_byte),
		.disp  (fetch.third_byte),
		.imm_n (fetch.fourth_byte),
		.dec   (idx_dec)
	);

	always_comb begin
		dec        = '0;
		dec.kind   = z80sid_pkg::K_UNKNOWN;
		dec.length = z80sid_pkg::LEN_1;
		if (b0 == z80sid_pkg::OP_NOP) begin
			dec.kind = z80sid_pkg::K_NOP;
		end else if (b0 == z80sid_pkg::OP_HALT) begin
			dec.kind = z80sid_pkg::K_HALT;
		end else if (b0 == z80sid_pkg::OP_RET) begin
			dec.kind = z80sid_pkg::K_RET;
		end else if (b0 == z80sid_pkg::OP_JP) begin
			dec.kind      = z80sid_pkg::K_JP;
			dec.length    = z80sid_pkg::LEN_3;
			dec.immediate = {fetch.third_byte, fetch.second_byte};
		end else if (b0 == z80sid_pkg::OP_JR) begin
			dec.kind      = z80sid_pkg::K_JR;
			dec.length    = z80sid_pkg::LEN_2;
			dec.immediate = {8'h00, fetch.second_byte};
		end else if (b0 == z80sid_pkg::OP_CALL) begin
			dec.kind      = z80sid_pkg::K_CALL;
			dec.length    = z80sid_pkg::LEN_3;
			dec.immediate = {fetch.third_byte, fetch.second_byte};
		end else if (b0 == z80sid_pkg::OP_LD_NN_A) begin
			dec.kind      = z80sid_pkg::K_LD_NN_A;
			dec.length    = z80sid_pkg::LEN_3;
			dec.immediate = {fetch.third_byte, fetch.second_byte};
		end else if (b0 == z80sid_pkg::OP_LD_A_NN) begin
			dec.kind      = z80sid_pkg::K_LD_A_NN;
			dec.length    = z80sid_pkg::LEN_3;
			dec.immediate = {fetch.third_byte, fetch.second_byte};
		end else if (b0 == z80sid_pkg::OP_PFX_IX || b0 == z80sid_pkg::OP_PFX_IY) begin
			dec = idx_dec;
		end else if ((b0 & z80sid_pkg::MASK_C0) == z80sid_pkg::PAT_LD_RR) begin
			if (hi == z80sid_pkg::REG_MEM) begin
				dec.kind            = z80sid_pkg::K_LD_HL_R;
				dec.source_register = lo;
			end else if (lo == z80sid_pkg::REG_MEM) begin
				dec.kind          = z80sid_pkg::K_LD_R_HL;
				dec.dest_register = hi;
			end else begin
				dec.kind            = z80sid_pkg::K_LD_R_R;
				dec.dest_register   = hi;
				dec.source_register = lo;
			end
		end else if ((b0 & z80sid_pkg::MASK_C7) == z80sid_pkg::PAT_LD_R_N) begin
			dec.kind          = z80sid_pkg::K_LD_R_N;
			dec.dest_register = hi;
			dec.length        = z80sid_pkg::LEN_2;
			dec.immediate     = {8'h00, fetch.second_byte};
		end else if ((b0 & z80sid_pkg::MASK_F8) == z80sid_pkg::PAT_ADD_R) begin
			dec.kind            = z80sid_pkg::K_ADD_R;
			dec.source_register = lo;
		end else if ((b0 & z80sid_pkg::MASK_F8) == z80sid_pkg::PAT_SUB_R) begin
			dec.kind            = z80sid_pkg::K_SUB_R;
			dec.source_register = lo;
		end else if ((b0 & z80sid_pkg::MASK_F8) == z80sid_pkg::PAT_CP_R) begin
			dec.kind            = z80sid_pkg::K_CP_R;
			dec.source_register = lo;
		end else if ((b0 & z80sid_pkg::MASK_C7) == z80sid_pkg::PAT_INC_R) begin
			dec.kind          = z80sid_pkg::K_INC_R;
			dec.dest_register = hi;
		end else if ((b0 & z80sid_pkg::MASK_C7) == z80sid_pkg::PAT_DEC_R) begin
			dec.kind          = z80sid_pkg::K_DEC_R;
			dec.dest_register = hi;
		end else if ((b0 & z80sid_pkg::MASK_F8) == z80sid_pkg::PAT_AND_R) begin
			dec.kind            = z80sid_pkg::K_AND_R;
			dec.source_register = lo;
		end else if ((b0 & z80sid_pkg::MASK_F8) == z80sid_pkg::PAT_OR_R) begin
			dec.kind            = z80sid_pkg::K_OR_R;
			dec.source_register = lo;
		end else if ((b0 & z80sid_pkg::MASK_F8) == z80sid_pkg::PAT_XOR_R) begin
			dec.kind            = z80sid_pkg::K_XOR_R;
			dec.source_register = lo;
		end else if ((b0 & z80sid_pkg::MASK_CF) == z80sid_pkg::PAT_PUSH) begin
			dec.kind            = z80sid_pkg::K_PUSH;
			dec.source_register = {1'b0, b0[5:4]};
		end else if ((b0 & z80sid_pkg::MASK_CF) == z80sid_pkg::PAT_POP) begin
			dec.kind          = z80sid_pkg::K_POP;
			dec.dest_register = {1'b0, b0[5:4]};
		end
	end

endmodule

[hw/rtl/z80_subset_instruction_decoder_unit.sv]
// ----------------------------------------------------------------------------
// z80_subset_instruction_decoder_unit
// Decodes a Z80 subset instruction from the four bytes at the program counter.
//
//   channel   dir   beat contents
//   s_*       in    four fetched bytes (first_byte in the low byte)
//   m_*       out   kind, length, immediate, source and dest register
//
// One beat in, one beat out. A beat passes through the input register and
// then the result register, one beat per cycle sustained while m_tready is
// held high. Reset clears both valid flags; payload is not reset. A stall
// on m_tready holds the result register, and the input register keeps
// taking beats while the result register has room.
// ----------------------------------------------------------------------------
module z80_subset_instruction_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // first_byte, second_byte, third_byte, fourth_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // kind[5:0], length[8:6], immediate[24:9],
	                              // source_register[27:25], dest_register[30:28]
);

	z80sid_pkg::fetch_t fetch_s1;
	logic               valid_s1;
	z80sid_pkg::dec_t   dec_comb;
	z80sid_pkg::dec_t   dec_s2;
	logic               valid_s2;
	logic               s2_ready;
	logic               s1_advance;

	assign s2_ready   = !valid_s2 || m_tready;
	assign s1_advance = valid_s1 && s2_ready;
	assign s_tready   = !valid_s1 || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			fetch_s1 <= z80sid_pkg::fetch_t'(s_tdata);
		end
	end

	z80sid_decode u_decode (
		.fetch (fetch_s1),
		.dec   (dec_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// advance the result only when a decoded beat moves up
	always_ff @(posedge clk) begin
		if (s1_advance) begin
			dec_s2 <= dec_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, dec_s2};

endmodule
